FILE: hw/rtl/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// Types and constants shared by the vertex normal stencil files.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COORD_W    = 10;
  localparam int UNIT_W     = 16;
  localparam int BASE_W     = 10;
  localparam int LOD_W      = 4;
  localparam int STEP_W     = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_RES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOD_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_STEP = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_height;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]         vertex_col;
    logic [COORD_W-1:0]         vertex_row;
    logic signed [SAMPLE_W-1:0] height;
    logic signed [UNIT_W-1:0]   normal_x;
    logic signed [UNIT_W-1:0]   normal_y;
    logic signed [UNIT_W-1:0]   normal_z;
    logic signed [UNIT_W-1:0]   tangent_x;
    logic signed [UNIT_W-1:0]   tangent_y;
    logic signed [UNIT_W-1:0]   bitangent_y;
    logic signed [UNIT_W-1:0]   bitangent_z;
    logic                       last_vertex;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic       start;
    logic [1:0] axis;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_FETCH, ST_NORMAL, ST_TANGENT, ST_BITANGENT, ST_FINISH
  } ctl_state_t;

  typedef enum logic [2:0] {
    U_IDLE, U_SHIFT, U_SQ, U_ROOT, U_DSET, U_DIV, U_DOUT, U_DONE
  } unit_state_t;

endpackage

FILE: hw/rtl/hvn_stream_if.sv
// ----------------------------------------------------------------------------
// hvn_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface hvn_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/heightfield_vertex_normal_stencil.sv
// ----------------------------------------------------------------------------
// heightfield_vertex_normal_stencil
// Raster-order height samples in, vertex height and unit normal, tangent and
// bitangent out, from central differences over two line stores.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   in      | in  | sample_height
//   out     | out | vertex fields, unit vectors, last_vertex
//   cfg     | in  | index, data (base_resolution, lod_shift, cell_step)
//
// A halo sample passes through the read and fetch states. A vertex sample
// also takes three passes of the normalizer, each a prescale shift (at most
// 9 with 24-bit heights), a 31-step square root and three 17-step
// divisions, or only the zero check for a zero vector.
// Synchronous reset; line stores need no clearing. A result waiting on out
// does not block the next sample until the following result is ready.
module heightfield_vertex_normal_stencil #(
  parameter int MAX_RESOLUTION = 512,
  parameter int HEIGHT_BITS    = 24
) (
  input  logic         clk,
  input  logic         rst,
  hvn_stream_if.sink   in,
  hvn_stream_if.source out,
  hvn_stream_if.sink   cfg
);

  localparam int DEPTH = MAX_RESOLUTION + 3;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RESOLUTION + 1);
  localparam int MW    = (HEIGHT_BITS > 24) ? HEIGHT_BITS : 24;
  localparam int CVW   = MW + 2;

  hvn_pkg::ctl_state_t state;
  logic [hvn_pkg::BASE_W-1:0] base_res;
  logic [hvn_pkg::LOD_W-1:0]  lod;
  logic [hvn_pkg::STEP_W-1:0] cell_step;
  logic [AW-1:0] gc, gr, cur_gc, cur_gr;
  logic signed [HEIGHT_BITS-1:0] h, mid, above, left_delay;
  logic signed [CVW-1:0] dx, dz;
  logic launched;
  logic signed [15:0] normal_v [3];
  logic signed [15:0] tangent_v [2];
  hvn_pkg::out_item_t res_q;

  logic [hvn_pkg::BASE_W-1:0] shifted;
  logic [RW-1:0] res;
  logic [AW-1:0] res_p1, res_p2, gc_eff, gr_eff, old_raddr, new_raddr;
  logic signed [31:0] s32, mid32;
  logic signed [HEIGHT_BITS-1:0] h_in, right;
  logic [HEIGHT_BITS-1:0] older_rdata, newer_rdata;
  logic signed [CVW-1:0] two_s;
  logic emit, wr, in_acc, load;
  logic [31:0] col32, row32;
  hvn_pkg::out_item_t res_next;
  hvn_pkg::unit_req_t req;
  hvn_pkg::unit_rsp_t rsp;
  logic signed [CVW-1:0] comp [3];
  logic signed [15:0] unit_out [3];

  always_comb begin
    shifted = base_res >> lod;
    if (shifted == '0) begin
      res = RW'(1);
    end else if ({22'b0, shifted} > 32'(MAX_RESOLUTION)) begin
      res = RW'(MAX_RESOLUTION);
    end else begin
      res = RW'(shifted);
    end
    res_p1 = AW'(res) + AW'(1);
    res_p2 = AW'(res) + AW'(2);
    if (gc > res_p2 || gr > res_p2) begin
      gc_eff = '0;
      gr_eff = '0;
    end else begin
      gc_eff = gc;
      gr_eff = gr;
    end
    s32   = 32'(in.data.sample_height);
    h_in  = s32[HEIGHT_BITS-1:0];
    right = newer_rdata;
    two_s = CVW'({cell_step, 1'b0});
    emit  = (cur_gr >= AW'(2)) && (cur_gc >= AW'(1)) && (cur_gc <= res_p1);
    in_acc = in.valid && in.ready;
    wr    = (state == hvn_pkg::ST_FETCH);
    old_raddr = (state == hvn_pkg::ST_IDLE) ? gc_eff : cur_gc;
    case (state)
      hvn_pkg::ST_IDLE: new_raddr = gc_eff;
      hvn_pkg::ST_READ: new_raddr = cur_gc + AW'(1);
      default:          new_raddr = cur_gc;
    endcase
    req.start = (state == hvn_pkg::ST_NORMAL || state == hvn_pkg::ST_TANGENT ||
                 state == hvn_pkg::ST_BITANGENT) && !launched;
    case (state)
      hvn_pkg::ST_NORMAL: begin
        comp[0] = -dx; comp[1] = two_s; comp[2] = -dz; req.axis = hvn_pkg::AXIS_Y;
      end
      hvn_pkg::ST_TANGENT: begin
        comp[0] = two_s; comp[1] = dx; comp[2] = '0; req.axis = hvn_pkg::AXIS_X;
      end
      default: begin
        comp[0] = dz; comp[1] = two_s; comp[2] = '0; req.axis = hvn_pkg::AXIS_Y;
      end
    endcase
    load  = (state == hvn_pkg::ST_FINISH) && (!out.valid || out.ready);
    col32 = 32'(cur_gc) - 32'd1;
    row32 = 32'(cur_gr) - 32'd2;
    mid32 = 32'(mid);
    // bitangent still sits on the idle normalizer's outputs
    res_next.vertex_col  = col32[hvn_pkg::COORD_W-1:0];
    res_next.vertex_row  = row32[hvn_pkg::COORD_W-1:0];
    res_next.height      = mid32[hvn_pkg::SAMPLE_W-1:0];
    res_next.normal_x    = normal_v[0];
    res_next.normal_y    = normal_v[1];
    res_next.normal_z    = normal_v[2];
    res_next.tangent_x   = tangent_v[0];
    res_next.tangent_y   = tangent_v[1];
    res_next.bitangent_y = unit_out[0];
    res_next.bitangent_z = unit_out[1];
    res_next.last_vertex = (cur_gc == res_p1) && (cur_gr == res_p2);
  end

  assign in.ready  = (state == hvn_pkg::ST_IDLE);
  assign cfg.ready = 1'b1;
  assign out.data  = res_q;

  hvn_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_older (
    .clk(clk), .we(wr), .waddr(cur_gc), .wdata(mid),
    .raddr(old_raddr), .rdata(older_rdata)
  );

  hvn_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_newer (
    .clk(clk), .we(wr), .waddr(cur_gc), .wdata(h),
    .raddr(new_raddr), .rdata(newer_rdata)
  );

  hvn_unitize #(.CW(CVW)) u_unit (
    .clk(clk), .rst(rst), .req(req), .comp(comp), .rsp(rsp), .unit_out(unit_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hvn_pkg::ST_IDLE;
      base_res   <= hvn_pkg::BASE_W'(512);
      lod        <= '0;
      cell_step  <= hvn_pkg::STEP_W'(256);
      gc         <= '0;
      gr         <= '0;
      left_delay <= '0;
      launched   <= 1'b0;
      out.valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          hvn_pkg::REG_BASE_RES:  base_res  <= cfg.data.data[hvn_pkg::BASE_W-1:0];
          hvn_pkg::REG_LOD_SHIFT: lod       <= cfg.data.data[hvn_pkg::LOD_W-1:0];
          hvn_pkg::REG_CELL_STEP: cell_step <= cfg.data.data;
          default: ;
        endcase
        if (cfg.data.index == hvn_pkg::REG_BASE_RES ||
            cfg.data.index == hvn_pkg::REG_LOD_SHIFT ||
            cfg.data.index == hvn_pkg::REG_CELL_STEP) begin
          gc         <= '0;
          gr         <= '0;
          left_delay <= '0;
        end
      end
      if (load) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
      if (req.start) begin
        launched <= 1'b1;
      end
      case (state)
        hvn_pkg::ST_IDLE: begin
          if (in_acc) begin
            cur_gc <= gc_eff;
            cur_gr <= gr_eff;
            h      <= h_in;
            state  <= hvn_pkg::ST_READ;
          end
        end
        hvn_pkg::ST_READ: begin
          mid   <= newer_rdata;
          above <= older_rdata;
          state <= hvn_pkg::ST_FETCH;
        end
        hvn_pkg::ST_FETCH: begin
          dx <= CVW'(right) - CVW'(left_delay);
          dz <= CVW'(h) - CVW'(above);
          if (cur_gc == res_p2) begin
            gc         <= '0;
            left_delay <= '0;
            gr         <= (cur_gr == res_p2) ? '0 : cur_gr + AW'(1);
          end else begin
            gc         <= cur_gc + AW'(1);
            gr         <= cur_gr;
            left_delay <= mid;
          end
          launched <= 1'b0;
          state    <= emit ? hvn_pkg::ST_NORMAL : hvn_pkg::ST_IDLE;
        end
        hvn_pkg::ST_NORMAL: begin
          if (rsp.done) begin
            normal_v[0] <= unit_out[0];
            normal_v[1] <= unit_out[1];
            normal_v[2] <= unit_out[2];
            launched    <= 1'b0;
            state       <= hvn_pkg::ST_TANGENT;
          end
        end
        hvn_pkg::ST_TANGENT: begin
          if (rsp.done) begin
            tangent_v[0] <= unit_out[0];
            tangent_v[1] <= unit_out[1];
            launched     <= 1'b0;
            state        <= hvn_pkg::ST_BITANGENT;
          end
        end
        hvn_pkg::ST_BITANGENT: begin
          if (rsp.done) begin
            launched <= 1'b0;
            state    <= hvn_pkg::ST_FINISH;
          end
        end
        hvn_pkg::ST_FINISH: begin
          if (load) begin
            res_q <= res_next;
            state <= hvn_pkg::ST_IDLE;
          end
        end
        default: state <= hvn_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hvn_ram.sv
// ----------------------------------------------------------------------------
// hvn_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 515
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/hvn_unitize.sv
// ----------------------------------------------------------------------------
// hvn_unitize
// Normalizes a three-component vector to Q1.15: prescale, sum of squares,
// bit-serial square root, then one bit-serial division per component.
// ----------------------------------------------------------------------------
module hvn_unitize #(
  parameter int CW = 26
) (
  input  logic                     clk,
  input  logic                     rst,
  input  hvn_pkg::unit_req_t       req,
  input  logic signed [CW-1:0]     comp [3],
  output hvn_pkg::unit_rsp_t       rsp,
  output logic signed [15:0]       unit_out [3]
);

  localparam int MW = CW - 1;

  hvn_pkg::unit_state_t state;
  logic [MW-1:0] mag [3];
  logic [2:0]    neg;
  logic [1:0]    axis;
  logic [1:0]    cnt;
  logic [31:0]   sum;
  logic [61:0]   xr;
  logic [30:0]   root;
  logic [34:0]   rem;
  logic [4:0]    rcnt;
  logic [31:0]   drem;
  logic [16:0]   nlow;
  logic [16:0]   q;

  logic [14:0] m15;
  logic [29:0] prod;
  logic [34:0] cur;
  logic [34:0] trial;
  logic [45:0] num;
  logic [32:0] dt;
  logic [31:0] dvs;
  logic [16:0] qc;
  logic        big;
  logic        zero;

  always_comb begin
    m15   = mag[cnt][14:0];
    prod  = {15'b0, m15} * {15'b0, m15};
    cur   = {rem[32:0], xr[61:60]};
    trial = {2'b0, root, 2'b01};
    num   = {1'b0, m15, 30'b0} + {15'b0, root};
    dvs   = {root, 1'b0};
    dt    = {drem, nlow[16]};
    qc    = (q > 17'd32768) ? 17'd32768 : q;
    big   = (mag[0][MW-1:15] != '0) || (mag[1][MW-1:15] != '0) ||
            (mag[2][MW-1:15] != '0);
    zero  = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  end

  assign rsp.done = (state == hvn_pkg::U_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hvn_pkg::U_IDLE;
    end else begin
      case (state)
        hvn_pkg::U_IDLE: begin
          if (req.start) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= comp[i][CW-1] ? MW'(-comp[i]) : MW'(comp[i]);
              neg[i] <= comp[i][CW-1];
            end
            axis  <= req.axis;
            state <= hvn_pkg::U_SHIFT;
          end
        end
        hvn_pkg::U_SHIFT: begin
          if (zero) begin
            for (int i = 0; i < 3; i++) begin
              unit_out[i] <= (2'(i) == axis) ? 16'sd32767 : 16'sd0;
            end
            state <= hvn_pkg::U_DONE;
          end else if (big) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            cnt   <= 2'd0;
            sum   <= '0;
            state <= hvn_pkg::U_SQ;
          end
        end
        hvn_pkg::U_SQ: begin
          sum <= sum + {2'b0, prod};
          cnt <= cnt + 2'd1;
          if (cnt == 2'd2) begin
            xr    <= {2'b0, sum + {2'b0, prod}, 28'b0};
            root  <= '0;
            rem   <= '0;
            rcnt  <= '0;
            state <= hvn_pkg::U_ROOT;
          end
        end
        hvn_pkg::U_ROOT: begin
          if (cur >= trial) begin
            rem  <= cur - trial;
            root <= {root[29:0], 1'b1};
          end else begin
            rem  <= cur;
            root <= {root[29:0], 1'b0};
          end
          xr   <= {xr[59:0], 2'b0};
          rcnt <= rcnt + 5'd1;
          if (rcnt == 5'd30) begin
            cnt   <= 2'd0;
            state <= hvn_pkg::U_DSET;
          end
        end
        hvn_pkg::U_DSET: begin
          drem  <= {3'b0, num[45:17]};
          nlow  <= num[16:0];
          q     <= '0;
          rcnt  <= '0;
          state <= hvn_pkg::U_DIV;
        end
        hvn_pkg::U_DIV: begin
          if (dt >= {1'b0, dvs}) begin
            drem <= 32'(dt - {1'b0, dvs});
            q    <= {q[15:0], 1'b1};
          end else begin
            drem <= dt[31:0];
            q    <= {q[15:0], 1'b0};
          end
          nlow <= {nlow[15:0], 1'b0};
          rcnt <= rcnt + 5'd1;
          if (rcnt == 5'd16) begin
            state <= hvn_pkg::U_DOUT;
          end
        end
        hvn_pkg::U_DOUT: begin
          if (neg[cnt]) begin
            unit_out[cnt] <= 16'(~qc + 17'd1);
          end else begin
            unit_out[cnt] <= (qc > 17'd32767) ? 16'sd32767 : qc[15:0];
          end
          cnt <= cnt + 2'd1;
          state <= (cnt == 2'd2) ? hvn_pkg::U_DONE : hvn_pkg::U_DSET;
        end
        hvn_pkg::U_DONE: begin
          state <= hvn_pkg::U_IDLE;
        end
        default: state <= hvn_pkg::U_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hvn_checker.sv
// ----------------------------------------------------------------------------
// hvn_checker
// Port-level checks for the vertex normal stencil.
// ----------------------------------------------------------------------------
module hvn_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [$bits(hvn_pkg::out_item_t)-1:0] out_data
);

  hvn_pkg::out_item_t item;
  assign item = out_data;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted on back-to-back cycles");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item.last_vertex |-> item.vertex_col == item.vertex_row)
    else $error("last vertex off the diagonal");

  a_up: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !item.normal_y[15])
    else $error("normal points down");

endmodule

bind heightfield_vertex_normal_stencil hvn_checker u_hvn_checker (
  .clk(clk), .rst(rst),
  .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready),
  .out_data(out.data)
);

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the vertex normal stencil against a cycle-free predictor that runs
// the same line-store stencil and fixed-point normalization. Directed chunks
// cover the height extremes, a zero cell step and out-of-range resolutions.
// Random chunks follow, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hvn_pkg::*;

  localparam int DEPTH = 515;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hvn_stream_if #(.T(in_item_t))  in_ch();
  hvn_stream_if #(.T(out_item_t)) out_ch();
  hvn_stream_if #(.T(cfg_item_t)) cfg_ch();

  heightfield_vertex_normal_stencil i_dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source), .cfg(cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [SAMPLE_W-1:0] pending_samples[$];
  out_item_t                  vertex_expect[$];
  int                         fail_count = 0;
  int                         queued = 0;
  bit                         calm = 1'b0;

  logic [BASE_W-1:0]          base_r = 10'd512;
  logic [LOD_W-1:0]           lod_r  = 4'd0;
  logic [STEP_W-1:0]          step_r = 23'd256;
  logic signed [SAMPLE_W-1:0] older_row[DEPTH];
  logic signed [SAMPLE_W-1:0] newer_row[DEPTH];
  logic signed [SAMPLE_W-1:0] left_d = '0;
  int unsigned                gcol = 0;
  int unsigned                grow = 0;

  function automatic int unsigned cur_res();
    int unsigned r;
    r = base_r >> lod_r;
    if (r < 1) r = 1;
    if (r > 512) r = 512;
    return r;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input longint c0, c1, c2, input int n, input int axis,
                                   output logic signed [UNIT_W-1:0] o0, o1, o2);
    longint          c[3];
    longint unsigned mag[3];
    longint unsigned m, sum, s, q;
    longint          v;
    logic signed [UNIT_W-1:0] o[3];
    int              k;
    c[0] = c0; c[1] = c1; c[2] = c2;
    m = 0; sum = 0; k = 0;
    for (int i = 0; i < n; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) o[i] = (i == axis) ? 16'sd32767 : 16'sd0;
    end else begin
      while ((m >> k) >= 32768) k++;
      for (int i = 0; i < n; i++) begin
        mag[i] = mag[i] >> k;
        sum = sum + mag[i] * mag[i];
      end
      s = isqrt(sum << 28);
      for (int i = 0; i < n; i++) begin
        q = ((mag[i] << 30) + s) / (2 * s);
        if (q > 32768) q = 32768;
        v = c[i] < 0 ? -longint'(q) : longint'(q);
        if (v > 32767) v = 32767;
        o[i] = v[UNIT_W-1:0];
      end
    end
    o0 = o[0]; o1 = o[1]; o2 = o[2];
  endfunction

  task automatic stencil_step(input logic signed [SAMPLE_W-1:0] h);
    int unsigned res, g;
    logic signed [SAMPLE_W-1:0] mid, prevl;
    longint dx, dz, two;
    logic signed [UNIT_W-1:0] d0;
    out_item_t e;
    res = cur_res();
    g = res + 3;
    if (gcol >= g || grow >= g) begin
      gcol = 0;
      grow = 0;
    end
    mid = newer_row[gcol];
    prevl = left_d;
    if (grow >= 2 && gcol >= 1 && gcol <= res + 1) begin
      dx = longint'(newer_row[gcol + 1]) - longint'(prevl);
      dz = longint'(h) - longint'(older_row[gcol]);
      two = 2 * longint'(step_r);
      e.vertex_col = COORD_W'(gcol - 1);
      e.vertex_row = COORD_W'(grow - 2);
      e.height = mid;
      unit_vec(-dx, two, -dz, 3, 1, e.normal_x, e.normal_y, e.normal_z);
      unit_vec(two, dx, 0, 2, 0, e.tangent_x, e.tangent_y, d0);
      unit_vec(dz, two, 0, 2, 1, e.bitangent_y, e.bitangent_z, d0);
      e.last_vertex = (gcol - 1 == res) && (grow - 2 == res);
      vertex_expect.insert(vertex_expect.size(), e);
    end
    older_row[gcol] = mid;
    newer_row[gcol] = h;
    left_d = mid;
    gcol++;
    if (gcol >= g) begin
      gcol = 0;
      left_d = '0;
      grow++;
      if (grow >= g) grow = 0;
    end
  endtask

  // sample driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) stencil_step(in_ch.data.sample_height);
      if (in_ch.valid && !in_ch.ready) begin
        in_ch.valid <= 1'b1;
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(1, 6) - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data.sample_height <= pending_samples.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result monitor
  int out_gap = 0;
  always @(posedge clk) begin
    out_item_t e, a;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        a = out_ch.data;
        if (vertex_expect.size() == 0) begin
          $error("vertex: expected none, actual col %0d row %0d", a.vertex_col, a.vertex_row);
          fail_count++;
        end else begin
          e = vertex_expect.pop_front();
          check_field("vertex_col", e.vertex_col, a.vertex_col);
          check_field("vertex_row", e.vertex_row, a.vertex_row);
          check_field("height", e.height, a.height);
          check_field("normal_x", e.normal_x, a.normal_x);
          check_field("normal_y", e.normal_y, a.normal_y);
          check_field("normal_z", e.normal_z, a.normal_z);
          check_field("tangent_x", e.tangent_x, a.tangent_x);
          check_field("tangent_y", e.tangent_y, a.tangent_y);
          check_field("bitangent_y", e.bitangent_y, a.bitangent_y);
          check_field("bitangent_z", e.bitangent_z, a.bitangent_z);
          check_field("last_vertex", e.last_vertex, a.last_vertex);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 6) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_BASE_RES:  base_r = val[BASE_W-1:0];
      REG_LOD_SHIFT: lod_r = val[LOD_W-1:0];
      default:       step_r = val[STEP_W-1:0];
    endcase
    gcol = 0;
    grow = 0;
    left_d = '0;
  endtask

  task automatic settle();
    while (pending_samples.size() > 0 || in_ch.valid || vertex_expect.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic setup(input int unsigned base, lod, step);
    settle();
    write_reg(REG_BASE_RES, base);
    write_reg(REG_LOD_SHIFT, lod);
    write_reg(REG_CELL_STEP, step);
  endtask

  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] v);
    pending_samples.insert(pending_samples.size(), v);
    queued++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_height(input int mode, input int i);
    case (mode)
      0:       return 24'($urandom());
      1:       return 24'sd1000 + $signed(24'($urandom_range(0, 63))) - 24'sd32;
      2:       return 24'(i * 97);
      default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  task automatic push_chunk(input int count, input int mode);
    for (int i = 0; i < count; i++) queue_sample(rand_height(mode, i));
  endtask

  initial begin
    int res, n, mode;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // extremes on a 2-cell chunk
    setup(2, 0, 256);
    for (int i = 0; i < 25; i++)
      queue_sample(i % 3 == 0 ? 24'h7FFFFF : (i % 3 == 1 ? 24'h800000 : 24'h0));
    // zero step with bumpy ground and with flat ground
    setup(1, 0, 0);
    push_chunk(16, 1);
    for (int i = 0; i < 16; i++) queue_sample(24'sd5);
    // zero resolution, maximal step
    setup(0, 3, 8388607);
    push_chunk(16, 0);
    setup(512, 9, 1);
    push_chunk(16, 3);
    // resolution above the cap, part of the first row of a chunk
    setup(1023, 0, 300);
    push_chunk(300, 0);
    setup(1023, 15, 8388607);
    push_chunk(16, 2);

    while (queued < 900) begin
      if (queued > 780) begin
        settle();
        calm = 1'b1;
      end
      case ($urandom_range(0, 5))
        0:       setup($urandom_range(1, 8), 0, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
        1:       setup($urandom_range(0, 1023), $urandom_range(7, 15), $urandom_range(1, 8388607));
        default: setup($urandom_range(1, 6), 0, $urandom_range(1, 4096));
      endcase
      res = cur_res();
      n = (res + 3) * (res + 3);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n + 10);
      mode = $urandom_range(0, 3);
      push_chunk(n, mode);
    end
    settle();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
